[rtl/datetime_compare_with_timezone_defines.svh]
// ---------------------------------------------------------------------------
// Date-time comparator assertion macros
// Shared concurrent assertion forms for the date-time comparator.
// ---------------------------------------------------------------------------
`ifndef DATETIME_COMPARE_WITH_TIMEZONE_DEFINES_SVH
`define DATETIME_COMPARE_WITH_TIMEZONE_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define DTZ_ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// An implication checked at every clock edge outside reset.
`define DTZ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[rtl/dtz_pkg.sv]
// ---------------------------------------------------------------------------
// Date-time comparator package
// Types, codes and small calendar helpers shared by the comparator modules.
// ---------------------------------------------------------------------------
package dtz_pkg;

	// Comparison modes.
	localparam logic [1:0] MODE_FULL = 2'd0;
	localparam logic [1:0] MODE_DATE = 2'd1;
	localparam logic [1:0] MODE_TIME = 2'd2;
	localparam logic [1:0] MODE_NONE = 2'd3;

	// Order codes on the result port.
	localparam logic signed [1:0] ORD_EQ = 2'sb00;
	localparam logic signed [1:0] ORD_GT = 2'sb01;
	localparam logic signed [1:0] ORD_LT = 2'sb11;

	// Reciprocal constants for the constant divisions.
	// 1310 / 2^15 under-estimates 1/25 by less than one over the 14-bit year range.
	localparam logic [10:0] Y25_RECIP = 11'd1310;
	// 1092 / 2^16 under-estimates 1/60 by less than one over the 12-bit range.
	localparam logic [10:0] M60_RECIP = 11'd1092;
	// Bias that makes the minute sum non-negative: eighteen hours of minutes.
	localparam logic [12:0] MIN_BIAS  = 13'd1080;

	// One unpacked date-time. The year is a 16-bit two's complement value.
	typedef struct packed {
		logic [15:0] year;
		logic [3:0]  mon;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  min;
		logic [25:0] usec;
	} stamp_t;

	// Length of a month; a month outside 1..12 counts 31 days.
	function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
		logic [4:0] len;
		unique case (mon)
			4'd2:                      len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

	// Gregorian leap test from the low four bits of a year and its remainder by 25.
	function automatic logic leap_low(input logic [3:0] low4, input logic [4:0] rem25);
		return (low4[1:0] == 2'd0) && ((rem25 != 5'd0) || (low4 == 4'd0));
	endfunction

endpackage

[rtl/datetime_compare_with_timezone.sv]
// ---------------------------------------------------------------------------
// Date-time comparator with time-zone normalisation
// Orders two packed date-times, optionally bringing zoned operands to UTC.
// ---------------------------------------------------------------------------
// Path: a taken request runs through the normaliser stages and the final
//   comparison stage; order and done are both driven from registers of
//   that last stage.
// Throughput: one request per cycle; the six-stage pipeline never stalls,
//   so busy stays low and results need no acknowledgement.
// Reset: arst_n clears the valid pipeline and done at once; data registers
//   keep whatever they hold and are never seen while done is low.
// ---------------------------------------------------------------------------
`include "datetime_compare_with_timezone_defines.svh"

module datetime_compare_with_timezone (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         mode,
	input  logic [22:0]        date_a,
	input  logic [36:0]        time_a,
	input  logic               zone_present_a,
	input  logic signed [10:0] zone_offset_a,
	input  logic [22:0]        date_b,
	input  logic [36:0]        time_b,
	input  logic               zone_present_b,
	input  logic signed [10:0] zone_offset_b,
	output logic               done,
	output logic signed [1:0]  order
);

	// The pipeline takes a request in every cycle, so it never holds one off.
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// Each operand is shifted only in full mode and only when it carries a zone.
	// In every other case the normaliser hands the raw fields through, which is
	// exactly what the date-only and time-only comparisons need.
	logic zone_on_a;
	logic zone_on_b;
	assign zone_on_a = zone_present_a && (mode == dtz_pkg::MODE_FULL);
	assign zone_on_b = zone_present_b && (mode == dtz_pkg::MODE_FULL);

	dtz_pkg::stamp_t stamp_a_s5;
	dtz_pkg::stamp_t stamp_b_s5;

	dtz_utc u_utc_a (
		.clk         (clk),
		.zone_on     (zone_on_a),
		.date        (date_a),
		.tm          (time_a),
		.zone_offset (zone_offset_a),
		.stamp_s5    (stamp_a_s5)
	);

	dtz_utc u_utc_b (
		.clk         (clk),
		.zone_on     (zone_on_b),
		.date        (date_b),
		.tm          (time_b),
		.zone_offset (zone_offset_b),
		.stamp_s5    (stamp_b_s5)
	);

	// The mode travels alongside the operands so that the final stage knows
	// which part of the key to compare.
	logic [1:0] mode_s1;
	logic [1:0] mode_s2;
	logic [1:0] mode_s3;
	logic [1:0] mode_s4;
	logic [1:0] mode_s5;

	always_ff @(posedge clk) begin
		mode_s1 <= mode;
		mode_s2 <= mode_s1;
		mode_s3 <= mode_s2;
		mode_s4 <= mode_s3;
		mode_s5 <= mode_s4;
	end

	// Valid bits, one per stage, cleared by reset.
	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic v_s4;
	logic v_s5;
	logic v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Stage 6: the comparison. The date key puts the year first with its sign
	// bit inverted, so that an unsigned compare orders the year -1 below year 0
	// and year 16384 above every raw year. Month and day follow. The time key is
	// hour, minute and microseconds; since seconds are held as whole
	// microseconds, equality within half a microsecond is exact equality here.
	logic [24:0] dkey_a_c;
	logic [24:0] dkey_b_c;
	logic [36:0] tkey_a_c;
	logic [36:0] tkey_b_c;
	logic signed [1:0] order_c;
	logic signed [1:0] order_s6;

	always_comb begin
		dkey_a_c = {~stamp_a_s5.year[15], stamp_a_s5.year[14:0],
			stamp_a_s5.mon, stamp_a_s5.day};
		dkey_b_c = {~stamp_b_s5.year[15], stamp_b_s5.year[14:0],
			stamp_b_s5.mon, stamp_b_s5.day};
		tkey_a_c = {stamp_a_s5.hour, stamp_a_s5.min, stamp_a_s5.usec};
		tkey_b_c = {stamp_b_s5.hour, stamp_b_s5.min, stamp_b_s5.usec};
		unique case (mode_s5)
			dtz_pkg::MODE_FULL: begin
				if ({dkey_a_c, tkey_a_c} > {dkey_b_c, tkey_b_c}) begin
					order_c = dtz_pkg::ORD_GT;
				end else if ({dkey_a_c, tkey_a_c} < {dkey_b_c, tkey_b_c}) begin
					order_c = dtz_pkg::ORD_LT;
				end else begin
					order_c = dtz_pkg::ORD_EQ;
				end
			end
			dtz_pkg::MODE_DATE: begin
				if (dkey_a_c > dkey_b_c) begin
					order_c = dtz_pkg::ORD_GT;
				end else if (dkey_a_c < dkey_b_c) begin
					order_c = dtz_pkg::ORD_LT;
				end else begin
					order_c = dtz_pkg::ORD_EQ;
				end
			end
			dtz_pkg::MODE_TIME: begin
				if (tkey_a_c > tkey_b_c) begin
					order_c = dtz_pkg::ORD_GT;
				end else if (tkey_a_c < tkey_b_c) begin
					order_c = dtz_pkg::ORD_LT;
				end else begin
					order_c = dtz_pkg::ORD_EQ;
				end
			end
			dtz_pkg::MODE_NONE: begin
				// The unused mode makes no comparison.
				order_c = dtz_pkg::ORD_EQ;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		order_s6 <= order_c;
	end

	assign done  = v_s6;
	assign order = order_s6;

	// Conditions on the request and the result that the checks below refer to.
	logic none_in;
	logic date_eq_in;
	logic order_eq;
	assign none_in    = (mode == dtz_pkg::MODE_NONE);
	assign date_eq_in = (mode == dtz_pkg::MODE_DATE) && (date_a == date_b);
	assign order_eq   = (order == dtz_pkg::ORD_EQ);

	// Every accepted request comes out at the end of the pipeline.
	`DTZ_ASSERT_IMPLY(a_latency, clk, arst_n, accept, ##6 done, "request lost in the pipeline")

	// Nothing comes out that was not accepted at the pipeline's input.
	`DTZ_ASSERT_IMPLY(a_no_phantom, clk, arst_n, done, $past(accept, 6), "result without a request")

	// The order code never takes the value that means nothing.
	`DTZ_ASSERT_IMPLY(a_order_code, clk, arst_n, done, order != 2'sb10, "bad order code")

	// The unused mode always reports equality.
	`DTZ_ASSERT_IMPLY(a_mode_none, clk, arst_n, done && $past(none_in, 6), order_eq, "unused mode")

	// Identical dates in date-only mode compare equal whatever the zones say.
	`DTZ_ASSERT_IMPLY(a_date_equal, clk, arst_n, done && $past(date_eq_in, 6), order_eq, "dates differ")

endmodule

[rtl/dtz_utc.sv]
// ---------------------------------------------------------------------------
// Date-time zone normaliser
// Five-stage pipeline that brings one zoned operand to UTC or passes it raw.
// ---------------------------------------------------------------------------
module dtz_utc (
	input  logic                 clk,
	input  logic                 zone_on,
	input  logic [22:0]          date,
	input  logic [36:0]          tm,
	input  logic signed [10:0]   zone_offset,
	output dtz_pkg::stamp_t      stamp_s5
);

	// Stage 1: unpack, biased minute sum, year quotient estimate by 25.
	dtz_pkg::stamp_t raw_c;
	logic [12:0]     u_c;
	logic [24:0]     prod25_c;

	dtz_pkg::stamp_t raw_s1;
	logic            on_s1;
	logic [11:0]     u_s1;
	logic [9:0]      q25_s1;

	always_comb begin
		raw_c.year = {2'b00, date[22:9]};
		raw_c.mon  = date[8:5];
		raw_c.day  = date[4:0];
		raw_c.hour = tm[36:32];
		raw_c.min  = tm[31:26];
		raw_c.usec = tm[25:0];
		u_c = {7'd0, tm[31:26]} + dtz_pkg::MIN_BIAS
			- {{2{zone_offset[10]}}, zone_offset};
		prod25_c = {11'd0, date[22:9]} * 25'(dtz_pkg::Y25_RECIP);
	end

	always_ff @(posedge clk) begin
		raw_s1 <= raw_c;
		on_s1  <= zone_on;
		u_s1   <= u_c[11:0];
		q25_s1 <= prod25_c[24:15];
	end

	// Stage 2: minute quotient estimate by 60, raw remainder of the year by 25.
	logic [22:0] prod60_c;
	logic [13:0] q25x_c;
	logic [13:0] r25w_c;

	dtz_pkg::stamp_t raw_s2;
	logic            on_s2;
	logic [11:0]     u_s2;
	logic [6:0]      qm_s2;
	logic [5:0]      r25_s2;

	always_comb begin
		prod60_c = {11'd0, u_s1} * 23'(dtz_pkg::M60_RECIP);
		q25x_c   = 14'(q25_s1) * 14'd25;
		r25w_c   = raw_s1.year[13:0] - q25x_c;
	end

	always_ff @(posedge clk) begin
		raw_s2 <= raw_s1;
		on_s2  <= on_s1;
		u_s2   <= u_s1;
		qm_s2  <= prod60_c[22:16];
		r25_s2 <= r25w_c[5:0];
	end

	// Stage 3: correct both quotients, leap flags for the year and its neighbours.
	logic [11:0] qm60_c;
	logic [11:0] rmw_c;
	logic [6:0]  rm_c;
	logic        ge60_c;
	logic [5:0]  min_c;
	logic [5:0]  cp_c;
	logic [4:0]  r25c_c;
	logic [4:0]  rdn_c;
	logic [4:0]  rup_c;
	logic [3:0]  ylo_c;

	dtz_pkg::stamp_t raw_s3;
	logic            on_s3;
	logic [5:0]      min_s3;
	logic [5:0]      cp_s3;
	logic            lp_dn_s3;
	logic            lp_0_s3;
	logic            lp_up_s3;

	always_comb begin
		qm60_c = 12'(qm_s2) * 12'd60;
		rmw_c  = u_s2 - qm60_c;
		rm_c   = rmw_c[6:0];
		ge60_c = (rm_c >= 7'd60);
		min_c  = ge60_c ? 6'(rm_c - 7'd60) : rm_c[5:0];
		cp_c   = 6'(qm_s2) + {5'd0, ge60_c};
		r25c_c = (r25_s2 >= 6'd25) ? 5'(r25_s2 - 6'd25) : r25_s2[4:0];
		rdn_c  = (r25c_c == 5'd0)  ? 5'd24 : r25c_c - 5'd1;
		rup_c  = (r25c_c == 5'd24) ? 5'd0  : r25c_c + 5'd1;
		ylo_c  = raw_s2.year[3:0];
	end

	always_ff @(posedge clk) begin
		raw_s3   <= raw_s2;
		on_s3    <= on_s2;
		min_s3   <= min_c;
		cp_s3    <= cp_c;
		lp_dn_s3 <= dtz_pkg::leap_low(ylo_c - 4'd1, rdn_c);
		lp_0_s3  <= dtz_pkg::leap_low(ylo_c, r25c_c);
		lp_up_s3 <= dtz_pkg::leap_low(ylo_c + 4'd1, rup_c);
	end

	// Stage 4: hour carry with floor by 24, shifted day.
	logic [6:0]        hp_c;
	logic [1:0]        dq_c;
	logic [6:0]        h24_c;
	logic [4:0]        hour_c;
	logic signed [6:0] d_c;

	dtz_pkg::stamp_t   raw_s4;
	logic              on_s4;
	logic [5:0]        min_s4;
	logic [4:0]        hour_s4;
	logic signed [6:0] d_s4;
	logic              lp_dn_s4;
	logic              lp_0_s4;
	logic              lp_up_s4;

	always_comb begin
		// The carry from the minutes is cp - 18; adding 24 keeps the sum positive.
		hp_c = 7'(raw_s3.hour) + 7'(cp_s3) + 7'd6;
		priority if (hp_c >= 7'd72) dq_c = 2'd3;
		else if (hp_c >= 7'd48)     dq_c = 2'd2;
		else if (hp_c >= 7'd24)     dq_c = 2'd1;
		else                        dq_c = 2'd0;
		h24_c  = 7'(dq_c) * 7'd24;
		hour_c = 5'(hp_c - h24_c);
		d_c    = $signed({2'b00, raw_s3.day}) + $signed({5'd0, dq_c}) - 7'sd1;
	end

	always_ff @(posedge clk) begin
		raw_s4   <= raw_s3;
		on_s4    <= on_s3;
		min_s4   <= min_s3;
		hour_s4  <= hour_c;
		d_s4     <= d_c;
		lp_dn_s4 <= lp_dn_s3;
		lp_0_s4  <= lp_0_s3;
		lp_up_s4 <= lp_up_s3;
	end

	// Stage 5: one month roll in either direction, then select raw or UTC.
	logic [13:0]       y_c;
	logic [3:0]        m_c;
	logic [4:0]        dim_cur_c;
	logic              borrow_c;
	logic              fwd_c;
	logic              dec_c;
	logic              inc_c;
	logic [3:0]        pm_c;
	logic [15:0]       py_c;
	logic              py_leap_c;
	logic [4:0]        dim_prev_c;
	logic signed [6:0] dsum_c;
	logic signed [6:0] dsub_c;
	dtz_pkg::stamp_t   utc_c;

	always_comb begin
		y_c       = raw_s4.year[13:0];
		m_c       = raw_s4.mon;
		dim_cur_c = dtz_pkg::month_days(m_c, lp_0_s4);
		borrow_c  = (d_s4 < 7'sd1);
		fwd_c     = !borrow_c && (d_s4 > $signed({2'b00, dim_cur_c}));

		// Previous month and the year it lies in.
		dec_c = (m_c < 4'd2);
		inc_c = (m_c >= 4'd14);
		if (dec_c) begin
			pm_c = m_c + 4'd11;
		end else if (inc_c) begin
			pm_c = m_c - 4'd13;
		end else begin
			pm_c = m_c - 4'd1;
		end
		py_c = {2'b00, y_c} + (dec_c ? 16'hFFFF : (inc_c ? 16'd1 : 16'd0));
		// A borrow into year zero, or below it, is measured as a common year.
		py_leap_c = (dec_c ? lp_dn_s4 : (inc_c ? lp_up_s4 : lp_0_s4))
			&& (py_c != 16'd0) && (py_c != 16'hFFFF);
		dim_prev_c = dtz_pkg::month_days(pm_c, py_leap_c);

		dsum_c = d_s4 + $signed({2'b00, dim_prev_c});
		dsub_c = d_s4 - $signed({2'b00, dim_cur_c});

		utc_c.hour = hour_s4;
		utc_c.min  = min_s4;
		utc_c.usec = raw_s4.usec;
		if (borrow_c) begin
			utc_c.year = py_c;
			utc_c.mon  = pm_c;
			utc_c.day  = dsum_c[4:0];
		end else if (fwd_c) begin
			utc_c.year = {2'b00, y_c} + 16'(m_c >= 4'd12);
			utc_c.mon  = (m_c >= 4'd12) ? m_c - 4'd11 : m_c + 4'd1;
			utc_c.day  = dsub_c[4:0];
		end else begin
			utc_c.year = {2'b00, y_c};
			utc_c.mon  = m_c;
			utc_c.day  = d_s4[4:0];
		end
	end

	always_ff @(posedge clk) begin
		stamp_s5 <= on_s4 ? utc_c : raw_s4;
	end

endmodule
